FILE: sv/fsmi_pkg.sv
// package for the first substring match index block
// types, register codes and widths shared by the cells, the tracker and the top level
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fsmi_pkg;

   localparam int PATTERN_MAX_DEFAULT = 32;
   localparam int BYTE_W              = 8;
   localparam int WORD_BYTES          = 8;
   localparam int POS_W               = 32;
   localparam int LEN_REG_W           = 6;
   localparam int CSR_INDEX_W         = 3;
   localparam int CSR_DATA_W          = 64;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PATTERN_LENGTH = 3'd0,
      REG_PATTERN_WORD_0 = 3'd1,
      REG_PATTERN_WORD_1 = 3'd2,
      REG_PATTERN_WORD_2 = 3'd3,
      REG_PATTERN_WORD_3 = 3'd4
   } fsmi_reg_type;

   // per-word control broadcast to every cell and the tracker
   typedef struct packed {
      logic take;
      logic is_end;
   } fsmi_ctrl_type;

endpackage

`default_nettype wire

FILE: sv/fsmi_cell.sv
// one pattern position of the match chain: pattern byte and progress bit
// depends on fsmi_pkg
`timescale 1ns / 1ps
`default_nettype none

module fsmi_cell
   import fsmi_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              pat_wr,
   input  wire logic [BYTE_W-1:0] pat_data,
   input  wire logic              enable,
   input  wire logic              is_last,
   input  wire fsmi_ctrl_type     ctrl,
   input  wire logic [BYTE_W-1:0] text_byte,
   input  wire logic              prev_in,
   output logic                   progress_out,
   output logic                   hit
);

   logic [BYTE_W-1:0] pat_ff;
   logic              progress_ff;
   logic              progress_in;

   // pattern byte register, loaded from the configuration port
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff <= '0;
      end else if (pat_wr) begin
         pat_ff <= pat_data;
      end
   end

   // progress extends when the previous position matched and this byte agrees
   assign progress_in = enable && prev_in && (pat_ff == text_byte);

   // completed match is flagged by the cell at the last used position
   assign hit = progress_in && is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         progress_ff <= 1'b0;
      end else if (ctrl.take) begin
         if (ctrl.is_end) begin
            progress_ff <= 1'b0;
         end else begin
            progress_ff <= progress_in;
         end
      end
   end

   assign progress_out = progress_ff;

endmodule

`default_nettype wire

FILE: sv/fsmi_tracker.sv
// text position counter, first hit record and result register
// depends on fsmi_pkg
`timescale 1ns / 1ps
`default_nettype none

module fsmi_tracker
   import fsmi_pkg::*;
#(
   parameter int LEN_W = LEN_REG_W
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire fsmi_ctrl_type    ctrl,
   input  wire logic             hit,
   input  wire logic [LEN_W-1:0] used_len,
   input  wire logic             rsp_stall,
   output logic                  rsp_valid,
   output logic                  rsp_found,
   output logic [POS_W-1:0]      rsp_match_index
);

   logic             pos_max;
   logic [POS_W-1:0] position_ff;
   logic             hit_seen_ff;
   logic [POS_W-1:0] hit_index_ff;
   logic             rsp_valid_ff;
   logic             found_ff;
   logic [POS_W-1:0] index_ff;
   logic             len_zero;
   logic [POS_W-1:0] start_index;

   assign len_zero    = (used_len == '0);
   assign start_index = position_ff - POS_W'(used_len) + POS_W'(1);
   assign pos_max     = &position_ff;

   // position counter and first hit, cleared on the end word
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         hit_seen_ff  <= 1'b0;
         hit_index_ff <= '0;
      end else if (ctrl.take) begin
         if (ctrl.is_end) begin
            position_ff  <= '0;
            hit_seen_ff  <= 1'b0;
            hit_index_ff <= '0;
         end else begin
            if (!pos_max) begin
               position_ff <= position_ff + POS_W'(1);
            end
            if (!len_zero && hit && !hit_seen_ff) begin
               hit_seen_ff  <= 1'b1;
               hit_index_ff <= start_index;
            end
         end
      end
   end

   // result register, held until the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.take && ctrl.is_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.take && ctrl.is_end) begin
         found_ff <= len_zero || hit_seen_ff;
         index_ff <= (!len_zero && hit_seen_ff) ? hit_index_ff : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_match_index = index_ff;

endmodule

`default_nettype wire

FILE: sv/first_substring_match_index.sv
// First substring match index. The text streams in one word per cycle on the
// req_ channel (req_text_byte, req_is_end) while req_stall is low; a word with
// req_is_end high closes the text. The pattern, up to PATTERN_MAX bytes, and
// its length are written through the csr_ port (index 0 length, 1 to 4 pattern
// words); csr_ready is always high. Write it only while no text is in flight.
// Each text word is broadcast to a row of cells, one per pattern position, that
// update their progress bits together, taking a word each unstalled cycle.
// Only the end word makes a result: rsp_found and rsp_match_index appear on the
// rsp_ channel in the cycle after the end word is accepted, and the search
// state is cleared for the next text at the same edge.
// While a result waits under rsp_stall, text words are still accepted; only a
// further end word is held back (req_stall) until the waiting result is taken.
// Reset clears the pattern, its length, the progress bits, the position counter
// and the result valid flag. The position counter saturates at its maximum.
// depends on fsmi_pkg, fsmi_cell, fsmi_tracker
`timescale 1ns / 1ps
`default_nettype none

module first_substring_match_index
   import fsmi_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [BYTE_W-1:0]      req_text_byte,
   input  wire logic                   req_is_end,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_found,
   output logic [POS_W-1:0]            rsp_match_index,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);

   logic [LEN_REG_W-1:0]   pattern_length_ff;
   logic [LEN_W-1:0]       used_len;
   logic                   csr_fire;
   fsmi_ctrl_type          ctrl;
   logic [PATTERN_MAX:0]   chain;
   logic [PATTERN_MAX-1:0] hits;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   // pattern length register
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
      end else if (csr_fire && csr_index == REG_PATTERN_LENGTH) begin
         pattern_length_ff <= csr_wdata[LEN_REG_W-1:0];
      end
   end

   // length clamped to the number of cells
   always_comb begin
      if (pattern_length_ff > LEN_REG_W'(PATTERN_MAX)) begin
         used_len = LEN_W'(PATTERN_MAX);
      end else begin
         used_len = LEN_W'(pattern_length_ff);
      end
   end

   // only an end word waits for the result register
   assign req_stall = rsp_valid && rsp_stall && req_is_end;
   assign ctrl.take   = req_valid && !req_stall;
   assign ctrl.is_end = req_is_end;

   // chain of match cells, position zero always has a matched predecessor
   assign chain[0] = 1'b1;

   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      localparam logic [CSR_INDEX_W-1:0] WORD_INDEX =
         CSR_INDEX_W'(int'(REG_PATTERN_WORD_0) + k / WORD_BYTES);
      localparam int LANE = k % WORD_BYTES;

      fsmi_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .pat_wr       (csr_fire && csr_index == WORD_INDEX),
         .pat_data     (csr_wdata[LANE*BYTE_W +: BYTE_W]),
         .enable       (LEN_W'(k) < used_len),
         .is_last      (used_len == LEN_W'(k + 1)),
         .ctrl         (ctrl),
         .text_byte    (req_text_byte),
         .prev_in      (chain[k]),
         .progress_out (chain[k+1]),
         .hit          (hits[k])
      );
   end

   fsmi_tracker #(
      .LEN_W (LEN_W)
   ) u_tracker (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .hit             (|hits),
      .used_len        (used_len),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found),
      .rsp_match_index (rsp_match_index)
   );

   // a new result appears only after an accepted end word
   a_result_from_end : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(ctrl.take && ctrl.is_end))
      else $error("result without an end word");

   // the input stalls only while a result is pending
   a_stall_needs_result : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no pending result");

   // an empty pattern always reports a match
   a_empty_found : assert property (@(posedge clock) disable iff (reset)
      (ctrl.take && ctrl.is_end && used_len == '0) |=> (rsp_valid && rsp_found))
      else $error("empty pattern not reported as found");

   // a miss reports index zero
   a_miss_index_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_match_index == '0))
      else $error("nonzero index on a miss");

endmodule

`default_nettype wire
